// ===== hdl/brb_pkg.sv =====
// Shared types, constants and helpers for the byte ring buffer with sequence tracking.
`timescale 1ns / 1ps
`default_nettype none
package brb_pkg;

    localparam int DEPTH     = 4096;
    localparam int MAX_BURST = 64;
    localparam int QDEPTH    = 2;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int SEQ_W   = 32;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 13;
    localparam int CMP_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
    localparam logic [OP_W-1:0] OP_READ   = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_SETSEQ = 3'd3;
    localparam logic [OP_W-1:0] OP_CLOSE  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BLOCK  = 2'd1;
    localparam logic [STAT_W-1:0] ST_CLOSED = 2'd2;

    typedef enum logic [2:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_PEEK,
        CMD_SETSEQ,
        CMD_CLOSE
    } t_cmd_kind;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_back_state;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  burst_len;
        logic              burst_first;
        logic              blocking;
        logic [SEQ_W-1:0]  seq_value;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic [STAT_W-1:0] status;
        logic              last;
        logic [FILL_W-1:0] fill_count;
        logic [SEQ_W-1:0]  first_seq;
        logic [SEQ_W-1:0]  next_seq;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  len;
        logic              first;
        logic              blocking;
        logic [SEQ_W-1:0]  seq_value;
    } t_cmd;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/brb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hdl/brb_front.sv =====
// Front end: accept input transfers, decode and clamp them, and queue commands.
`timescale 1ns / 1ps
`default_nettype none
module brb_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire brb_pkg::t_in_item i_in_item,
    output logic                   o_cmd_valid,
    output brb_pkg::t_cmd          o_cmd,
    input  wire logic              i_cmd_pop
);

    brb_pkg::t_cmd                r_q [brb_pkg::QDEPTH];
    logic [brb_pkg::QPTR_W-1:0]   r_wptr;
    logic [brb_pkg::QPTR_W-1:0]   r_rptr;
    logic [brb_pkg::QCNT_W-1:0]   r_cnt;
    brb_pkg::t_cmd                cmd;
    logic                         cmd_ok;
    logic                         push;
    logic                         pop;

    always_comb begin
        cmd.data_byte = i_in_item.data_byte;
        cmd.first     = i_in_item.burst_first;
        cmd.blocking  = i_in_item.blocking;
        cmd.seq_value = i_in_item.seq_value;
        cmd.len       = (i_in_item.burst_len > brb_pkg::LEN_W'(brb_pkg::MAX_BURST))
                        ? brb_pkg::LEN_W'(brb_pkg::MAX_BURST) : i_in_item.burst_len;
        cmd.kind      = brb_pkg::CMD_WRITE;
        cmd_ok        = 1'b1;
        unique case (i_in_item.op)
            brb_pkg::OP_WRITE:  cmd.kind = brb_pkg::CMD_WRITE;
            brb_pkg::OP_READ:   cmd.kind = brb_pkg::CMD_READ;
            brb_pkg::OP_PEEK:   cmd.kind = brb_pkg::CMD_PEEK;
            brb_pkg::OP_SETSEQ: cmd.kind = brb_pkg::CMD_SETSEQ;
            brb_pkg::OP_CLOSE:  cmd.kind = brb_pkg::CMD_CLOSE;
            default:            cmd_ok   = 1'b0;
        endcase
    end

    assign o_in_stall  = (r_cnt == brb_pkg::QCNT_W'(brb_pkg::QDEPTH));
    assign push        = i_in_valid && !o_in_stall && cmd_ok;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == brb_pkg::QPTR_W'(brb_pkg::QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == brb_pkg::QPTR_W'(brb_pkg::QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/brb_back.sv =====
// Back end: ring state, sequence counters, read bursts and the result register.
`timescale 1ns / 1ps
`default_nettype none
module brb_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire brb_pkg::t_cmd      i_cmd,
    output logic                    o_cmd_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output brb_pkg::t_out_item      o_out_item
);

    brb_pkg::t_back_state          r_state, n_state;
    logic [brb_pkg::PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [brb_pkg::PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [brb_pkg::PTR_W-1:0]     r_p, n_p;
    logic [brb_pkg::CNT_W-1:0]     r_held, n_held;
    logic [brb_pkg::SEQ_W-1:0]     r_start, n_start;
    logic [brb_pkg::SEQ_W-1:0]     r_end, n_end;
    logic                          r_closed, n_closed;
    logic                          r_refused, n_refused;
    logic [brb_pkg::LEN_W-1:0]     r_remain, n_remain;
    logic                          r_consume, n_consume;
    logic                          r_out_valid, n_out_valid;
    brb_pkg::t_out_item            r_out, n_out;

    logic                          out_free;
    logic                          we;
    logic [brb_pkg::BYTE_W-1:0]    rdata;
    logic                          emit;
    logic [brb_pkg::BYTE_W-1:0]    emit_byte;
    logic [brb_pkg::STAT_W-1:0]    emit_status;
    logic                          emit_last;
    logic                          blocked;
    logic [brb_pkg::CMP_W-1:0]     free_cmp;
    logic [brb_pkg::CMP_W-1:0]     len_cmp;
    logic [brb_pkg::CMP_W-1:0]     held_cmp;
    logic [brb_pkg::CMP_W-1:0]     take;

    brb_ram #(
        .WIDTH (brb_pkg::BYTE_W),
        .DEPTH (brb_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_cmd.data_byte),
        .i_raddr (n_p),
        .o_rdata (rdata)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign held_cmp = brb_pkg::CMP_W'(r_held);
    assign len_cmp  = brb_pkg::CMP_W'(i_cmd.len);
    assign free_cmp = brb_pkg::CMP_W'(brb_pkg::DEPTH) - held_cmp;
    assign take     = (len_cmp < held_cmp) ? len_cmp : held_cmp;

    always_comb begin
        n_state     = r_state;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_p         = r_p;
        n_held      = r_held;
        n_start     = r_start;
        n_end       = r_end;
        n_closed    = r_closed;
        n_refused   = r_refused;
        n_remain    = r_remain;
        n_consume   = r_consume;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        we          = 1'b0;
        emit        = 1'b0;
        emit_byte   = '0;
        emit_status = brb_pkg::ST_OK;
        emit_last   = 1'b1;
        blocked     = 1'b0;

        unique case (r_state)
            brb_pkg::BK_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        brb_pkg::CMD_WRITE: begin
                            emit = 1'b1;
                            if (r_closed) begin
                                emit_status = brb_pkg::ST_CLOSED;
                            end else begin
                                if (i_cmd.first) begin
                                    if (!i_cmd.blocking && (free_cmp < len_cmp)) begin
                                        n_refused = 1'b1;
                                        blocked   = 1'b1;
                                    end else begin
                                        n_refused = 1'b0;
                                    end
                                end else if (r_refused) begin
                                    blocked = 1'b1;
                                end
                                if (r_held == brb_pkg::CNT_W'(brb_pkg::DEPTH)) begin
                                    blocked = 1'b1;
                                end
                                if (blocked) begin
                                    emit_status = brb_pkg::ST_BLOCK;
                                end else begin
                                    we       = 1'b1;
                                    n_wr_ptr = brb_pkg::ptr_inc(r_wr_ptr);
                                    n_held   = r_held + 1'b1;
                                    n_end    = r_end + 1'b1;
                                end
                            end
                        end
                        brb_pkg::CMD_READ, brb_pkg::CMD_PEEK: begin
                            if (r_closed) begin
                                emit        = 1'b1;
                                emit_status = brb_pkg::ST_CLOSED;
                            end else if (r_held == '0) begin
                                emit        = 1'b1;
                                emit_status = brb_pkg::ST_BLOCK;
                            end else if (take != '0) begin
                                n_p       = r_rd_ptr;
                                n_remain  = brb_pkg::LEN_W'(take);
                                n_consume = (i_cmd.kind == brb_pkg::CMD_READ);
                                n_state   = brb_pkg::BK_READ;
                            end
                        end
                        brb_pkg::CMD_SETSEQ: begin
                            emit    = 1'b1;
                            n_start = i_cmd.seq_value;
                            n_end   = i_cmd.seq_value + brb_pkg::SEQ_W'(r_wr_ptr);
                        end
                        brb_pkg::CMD_CLOSE: begin
                            emit     = 1'b1;
                            n_closed = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            brb_pkg::BK_READ: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_byte = rdata;
                    emit_last = (r_remain == brb_pkg::LEN_W'(1));
                    n_p       = brb_pkg::ptr_inc(r_p);
                    n_remain  = r_remain - 1'b1;
                    if (r_consume) begin
                        n_rd_ptr = brb_pkg::ptr_inc(r_p);
                        n_held   = r_held - 1'b1;
                        n_start  = r_start + 1'b1;
                    end
                    if (r_remain == brb_pkg::LEN_W'(1)) begin
                        n_state = brb_pkg::BK_IDLE;
                    end
                end
            end
            default: n_state = brb_pkg::BK_IDLE;
        endcase

        if (emit) begin
            n_out_valid      = 1'b1;
            n_out.data_out   = emit_byte;
            n_out.status     = emit_status;
            n_out.last       = emit_last;
            n_out.fill_count = brb_pkg::FILL_W'(n_held);
            n_out.first_seq  = n_start;
            n_out.next_seq   = n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brb_pkg::BK_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_p         <= '0;
            r_held      <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_closed    <= 1'b0;
            r_refused   <= 1'b0;
            r_remain    <= '0;
            r_consume   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_p         <= n_p;
            r_held      <= n_held;
            r_start     <= n_start;
            r_end       <= n_end;
            r_closed    <= n_closed;
            r_refused   <= n_refused;
            r_remain    <= n_remain;
            r_consume   <= n_consume;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// ===== hdl/byte_ring_buffer_with_sequence.sv =====
// Top level of the byte ring buffer with sequence tracking.
// An input transfer is queued in the front end, then its result is registered by the back end.
// Throughput: one single-result item per cycle while the output is free; a read/peek of n bytes holds the back end
// for one RAM read setup, then one byte per cycle from the registered RAM port while the output is free.
// Reset: synchronous, active low; clears pointers, counts, sequences, flags and the queue.
// The byte store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module byte_ring_buffer_with_sequence (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire brb_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output brb_pkg::t_out_item      o_out_item
);

    logic          cmd_valid;
    logic          cmd_pop;
    brb_pkg::t_cmd cmd;

    brb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    brb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// ===== hdl/brb_checker.sv =====
// Port-level checks for the byte ring buffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module brb_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire brb_pkg::t_out_item o_out_item
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stalled_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.fill_count <= brb_pkg::FILL_W'(brb_pkg::DEPTH))
        else $error("fill count above depth");

    a_error_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != brb_pkg::ST_OK
            |-> o_out_item.last && o_out_item.data_out == '0)
        else $error("error result not final or carries data");

endmodule

bind byte_ring_buffer_with_sequence brb_checker u_brb_checker (.*);
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the byte ring buffer with sequence tracking: directed table, bulk fill and random traffic.
`timescale 1ns / 1ps
module tb_top;
    import brb_pkg::*;

    localparam int IN_W         = $bits(t_in_item);
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 100;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 55;
    localparam int N_PHASES     = 4;
    localparam int SEND_PCT [N_PHASES]  = '{0, 53, 0, 37};
    localparam int STALL_PCT [N_PHASES] = '{0, 0, 53, 37};

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_vec_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int err_cnt       = 0;
    int cycle_cnt     = 0;

    logic [BYTE_W-1:0] ring_mem [DEPTH];
    int                ring_rd       = 0;
    int                ring_wr       = 0;
    int                ring_held     = 0;
    logic [SEQ_W-1:0]  seq_first     = '0;
    logic [SEQ_W-1:0]  seq_next      = '0;
    logic              ring_closed   = 1'b0;
    logic              burst_dropped = 1'b0;

    t_out_item step_results[$];
    t_out_item pending_results[$];
    t_out_item head_result;
    t_vec_row  dir_vec[$];

    byte_ring_buffer_with_sequence DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_in_item mk_in(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                       logic [LEN_W-1:0] len, logic first, logic blk,
                                       logic [SEQ_W-1:0] seq);
        t_in_item it;
        it.op          = op;
        it.data_byte   = data;
        it.burst_len   = len;
        it.burst_first = first;
        it.blocking    = blk;
        it.seq_value   = seq;
        return it;
    endfunction

    function automatic t_out_item mk_out(logic [STAT_W-1:0] st, int fill,
                                         logic [SEQ_W-1:0] fs, logic [SEQ_W-1:0] ns);
        t_out_item r;
        r.data_out   = '0;
        r.status     = st;
        r.last       = 1'b1;
        r.fill_count = FILL_W'(fill);
        r.first_seq  = fs;
        r.next_seq   = ns;
        return r;
    endfunction

    function automatic void add_row(t_in_item it, logic typed, t_out_item want);
        t_vec_row r;
        r.item  = it;
        r.typed = typed;
        r.want  = want;
        dir_vec.push_back(r);
    endfunction

    function automatic void ring_add(logic [BYTE_W-1:0] data, logic [STAT_W-1:0] st,
                                     logic last);
        t_out_item r;
        r.data_out   = data;
        r.status     = st;
        r.last       = last;
        r.fill_count = FILL_W'(ring_held);
        r.first_seq  = seq_first;
        r.next_seq   = seq_next;
        step_results.push_back(r);
    endfunction

    function automatic void ring_step(t_in_item it);
        int                len_eff;
        int                take;
        int                p;
        logic              drop;
        logic [BYTE_W-1:0] b;
        step_results.delete();
        len_eff = (it.burst_len > MAX_BURST) ? MAX_BURST : int'(it.burst_len);
        drop = 1'b0;
        case (it.op)
            OP_WRITE: begin
                if (ring_closed) begin
                    ring_add('0, ST_CLOSED, 1'b1);
                end else begin
                    if (it.burst_first) begin
                        if (!it.blocking && DEPTH - ring_held < len_eff) begin
                            burst_dropped = 1'b1;
                            drop = 1'b1;
                        end else begin
                            burst_dropped = 1'b0;
                        end
                    end else if (burst_dropped) begin
                        drop = 1'b1;
                    end
                    if (ring_held >= DEPTH) drop = 1'b1;
                    if (drop) begin
                        ring_add('0, ST_BLOCK, 1'b1);
                    end else begin
                        ring_mem[ring_wr] = it.data_byte;
                        ring_wr = (ring_wr + 1) % DEPTH;
                        ring_held++;
                        seq_next++;
                        ring_add('0, ST_OK, 1'b1);
                    end
                end
            end
            OP_READ, OP_PEEK: begin
                if (ring_closed) begin
                    ring_add('0, ST_CLOSED, 1'b1);
                end else if (ring_held == 0) begin
                    ring_add('0, ST_BLOCK, 1'b1);
                end else begin
                    take = (len_eff < ring_held) ? len_eff : ring_held;
                    p = ring_rd;
                    for (int i = 0; i < take; i++) begin
                        b = ring_mem[p];
                        p = (p + 1) % DEPTH;
                        if (it.op == OP_READ) begin
                            ring_rd = p;
                            ring_held--;
                            seq_first++;
                        end
                        ring_add(b, ST_OK, i + 1 == take);
                    end
                end
            end
            OP_SETSEQ: begin
                seq_first = it.seq_value;
                seq_next  = it.seq_value + SEQ_W'(ring_wr);
                ring_add('0, ST_OK, 1'b1);
            end
            OP_CLOSE: begin
                ring_closed = 1'b1;
                ring_add('0, ST_OK, 1'b1);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            err_cnt++;
        end
    endfunction

    function automatic t_in_item rand_item();
        return IN_W'({$urandom(), $urandom()});
    endfunction

    task automatic send_item(t_in_item it, logic typed, t_out_item want);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        ring_step(it);
        if (typed) begin
            pending_results.push_back(want);
        end else begin
            foreach (step_results[k]) pending_results.push_back(step_results[k]);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic run_rows(int lo, int hi);
        for (int i = lo; i < hi; i++) send_item(dir_vec[i].item, dir_vec[i].typed, dir_vec[i].want);
    endtask

    task automatic send_write(logic first, logic blk, logic [LEN_W-1:0] len);
        send_item(mk_in(OP_WRITE, 8'($urandom()), len, first, blk, $urandom()), 1'b0, '0);
    endtask

    task automatic run_fill();
        t_in_item it;
        int       room;
        room = DEPTH - 6 - ring_held;
        for (int k = 0; k < room; k++) begin
            it = rand_item();
            it.op = OP_WRITE;
            it.burst_first = (k == 0);
            if (k == 0) it.blocking = 1'b1;
            send_item(it, 1'b0, '0);
        end
        send_write(1'b1, 1'b0, 7'd64);
        send_write(1'b0, 1'b0, 7'd0);
        send_write(1'b0, 1'b1, 7'd127);
        send_write(1'b1, 1'b0, 7'd6);
        for (int k = 0; k < 5; k++) send_write(1'b0, 1'($urandom()), 7'($urandom()));
        send_item(mk_in(OP_PEEK, 8'($urandom()), 7'd64, 1'b0, 1'b0, $urandom()), 1'b0, '0);
        send_write(1'b1, 1'b1, 7'd1);
        send_write(1'b1, 1'b0, 7'd0);
        send_write(1'b0, 1'b0, 7'd1);
        while (ring_held > 0) begin
            send_item(mk_in(OP_READ, 8'($urandom()), 7'd127, 1'($urandom()), 1'($urandom()),
                            $urandom()), 1'b0, '0);
        end
    endtask

    task automatic run_random(int target);
        t_in_item it;
        int       cnt;
        int       pick;
        int       blen;
        int       nbytes;
        logic     blk;
        cnt = 0;
        while (cnt < target) begin
            it = rand_item();
            pick = $urandom_range(99);
            if (pick < 45) begin
                blen = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, MAX_BURST);
                nbytes = (blen > MAX_BURST) ? MAX_BURST : ((blen == 0) ? 1 : blen);
                if ($urandom_range(7) == 0) nbytes = $urandom_range(1, nbytes);
                blk = 1'($urandom());
                for (int k = 0; k < nbytes; k++) begin
                    it = rand_item();
                    it.op = OP_WRITE;
                    it.burst_first = (k == 0);
                    it.blocking = blk;
                    if (k == 0) it.burst_len = LEN_W'(blen);
                    send_item(it, 1'b0, '0);
                end
                cnt += nbytes;
            end else if (pick < 55) begin
                it.op = OP_WRITE;
                send_item(it, 1'b0, '0);
                cnt++;
            end else if (pick < 85) begin
                it.op = $urandom_range(1) ? OP_READ : OP_PEEK;
                if ($urandom_range(4) != 0) it.burst_len = LEN_W'($urandom_range(1, MAX_BURST));
                send_item(it, 1'b0, '0);
                cnt++;
            end else if (pick < 94) begin
                it.op = OP_SETSEQ;
                send_item(it, 1'b0, '0);
                cnt++;
            end else begin
                it.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                send_item(it, 1'b0, '0);
            end
        end
    endtask

    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending");
                err_cnt++;
            end else begin
                head_result = pending_results.pop_front();
                check_field("data_out", 32'(head_result.data_out), 32'(out_item.data_out));
                check_field("status", 32'(head_result.status), 32'(out_item.status));
                check_field("last", 32'(head_result.last), 32'(out_item.last));
                check_field("fill_count", 32'(head_result.fill_count), 32'(out_item.fill_count));
                check_field("first_seq", head_result.first_seq, out_item.first_seq);
                check_field("next_seq", head_result.next_seq, out_item.next_seq);
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int close_at;
        add_row(mk_in(OP_READ, 8'h00, 7'd1, 1'b0, 1'b0, 32'h0), 1'b1,
                mk_out(ST_BLOCK, 0, 32'h0, 32'h0));
        add_row(mk_in(OP_PEEK, 8'hFF, 7'd64, 1'b1, 1'b1, 32'hFFFF_FFFF), 1'b1,
                mk_out(ST_BLOCK, 0, 32'h0, 32'h0));
        add_row(mk_in(OP_SPARE_LO, 8'h00, 7'd0, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_SPARE_HI, 8'hFF, 7'h7F, 1'b1, 1'b1, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(mk_in(OP_SETSEQ, 8'h00, 7'd0, 1'b0, 1'b0, 32'hFFFF_FFFF), 1'b1,
                mk_out(ST_OK, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_row(mk_in(OP_WRITE, 8'h00, 7'd1, 1'b1, 1'b1, 32'h0), 1'b1,
                mk_out(ST_OK, 1, 32'hFFFF_FFFF, 32'h0));
        add_row(mk_in(OP_WRITE, 8'hFF, 7'd127, 1'b1, 1'b0, 32'h0), 1'b1,
                mk_out(ST_OK, 2, 32'hFFFF_FFFF, 32'h1));
        add_row(mk_in(OP_WRITE, 8'hA5, 7'd0, 1'b0, 1'b0, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(mk_in(OP_WRITE, 8'h5A, 7'd64, 1'b0, 1'b1, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_PEEK, 8'h00, 7'd2, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_PEEK, 8'h00, 7'd0, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_READ, 8'h00, 7'd0, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_READ, 8'h00, 7'd1, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_PEEK, 8'h00, 7'd127, 1'b1, 1'b1, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_SETSEQ, 8'h00, 7'd0, 1'b0, 1'b0, 32'h0), 1'b1,
                mk_out(ST_OK, 3, 32'h0, 32'h4));
        add_row(mk_in(OP_READ, 8'h00, 7'd64, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_READ, 8'h00, 7'd2, 1'b0, 1'b0, 32'h0), 1'b1,
                mk_out(ST_BLOCK, 0, 32'h3, 32'h4));
        add_row(mk_in(OP_SETSEQ, 8'h00, 7'd0, 1'b0, 1'b0, 32'h8000_0000), 1'b1,
                mk_out(ST_OK, 0, 32'h8000_0000, 32'h8000_0004));
        add_row(mk_in(OP_WRITE, 8'h3C, 7'd1, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_READ, 8'h00, 7'd1, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        close_at = dir_vec.size();
        add_row(mk_in(OP_CLOSE, 8'h00, 7'd0, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_WRITE, 8'h77, 7'd1, 1'b1, 1'b1, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_WRITE, 8'h11, 7'd1, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_READ, 8'h00, 7'd1, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_PEEK, 8'h00, 7'd64, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_READ, 8'h00, 7'd0, 1'b0, 1'b0, 32'h0), 1'b0, '0);
        add_row(mk_in(OP_SETSEQ, 8'h00, 7'd0, 1'b0, 1'b0, 32'h1234_5678), 1'b0, '0);
        add_row(mk_in(OP_CLOSE, 8'hFF, 7'h7F, 1'b1, 1'b1, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(mk_in(OP_SPARE_MID, 8'h00, 7'd1, 1'b0, 1'b0, 32'h0), 1'b0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_rows(0, close_at);
        wait_drained();
        hold_token++;
        run_fill();
        wait_drained();
        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct = SEND_PCT[ph];
            stall_pct     = STALL_PCT[ph];
            run_random(RANDOM_ITEMS);
            wait_drained();
        end
        send_idle_pct = 0;
        stall_pct     = 0;
        run_rows(close_at, dir_vec.size());
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
